@@ design/key_debounce_press_release_longhold_assert.svh @@
// Assertion macros for the key debounce block and its checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef KEY_DEBOUNCE_PRESS_RELEASE_LONGHOLD_ASSERT_SVH
`define KEY_DEBOUNCE_PRESS_RELEASE_LONGHOLD_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define KDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/kdb_pkg.sv @@
// Shared types and constants of the key debounce block.
// No dependencies; used by every module of the block.
package kdb_pkg;

  localparam logic [1:0] KEY_UP      = 2'd0;
  localparam logic [1:0] KEY_DOWN    = 2'd1;
  localparam logic [1:0] KEY_CONFIRM = 2'd2;
  localparam logic [1:0] NO_KEY      = 2'd3;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_RESET = 3'd4;

  localparam logic [15:0] LONG_HOLD_RESET = 16'd50;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } ev_kind_e;

  // Filtered sample handed from the debounce filter to the tracker.
  typedef struct packed {
    logic       stable;
    logic [1:0] code;
  } filt_t;

  typedef struct packed {
    ev_kind_e   kind;
    logic [1:0] key_id;
    logic [2:0] action;
    logic [1:0] held_key;
  } result_t;

endpackage

@@ design/kdb_filter.sv @@
// Pin encoder and sample history of the key debounce block.
// Depends on kdb_pkg.
module kdb_filter #(
  parameter int unsigned FILTER_DEPTH = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [2:0]           pin_levels_i,
  output kdb_pkg::filt_t       filt_o
);
  import kdb_pkg::*;

  logic [1:0] hist_q [FILTER_DEPTH];
  logic [1:0] hist_d [FILTER_DEPTH];
  logic [1:0] code;
  logic       stable;

  // Lowest-numbered pressed pin wins; pins are active low.
  always_comb begin
    if (!pin_levels_i[0]) begin
      code = KEY_UP;
    end else if (!pin_levels_i[1]) begin
      code = KEY_DOWN;
    end else if (!pin_levels_i[2]) begin
      code = KEY_CONFIRM;
    end else begin
      code = NO_KEY;
    end
  end

  always_comb begin
    hist_d[0] = code;
    for (int i = 1; i < FILTER_DEPTH; i++) begin
      hist_d[i] = hist_q[i-1];
    end
    stable = 1'b1;
    for (int i = 1; i < FILTER_DEPTH; i++) begin
      if (hist_d[i] != code) stable = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FILTER_DEPTH; i++) hist_q[i] <= NO_KEY;
    end else if (step_i) begin
      for (int i = 0; i < FILTER_DEPTH; i++) hist_q[i] <= hist_d[i];
    end
  end

  assign filt_o.stable = stable;
  assign filt_o.code   = code;

endmodule

@@ design/kdb_tracker.sv @@
// Press, release and long-hold tracking of the key debounce block.
// Depends on kdb_pkg.
module kdb_tracker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  kdb_pkg::filt_t   filt_i,
  input  logic [15:0]      long_hold_ticks_i,
  output kdb_pkg::result_t result_o
);
  import kdb_pkg::*;

  logic [1:0]  last_q, last_d;
  logic [1:0]  committed_q, committed_d;
  logic [15:0] hold_q, hold_d;
  logic        long_seen_q, long_seen_d;
  logic [15:0] hold_inc;
  ev_kind_e    kind;
  logic [1:0]  key;
  logic [2:0]  action;

  assign hold_inc = hold_q + 16'd1;

  always_comb begin
    last_d      = last_q;
    committed_d = committed_q;
    hold_d      = hold_q;
    kind        = EV_NONE;
    key         = KEY_UP;
    if (filt_i.stable) begin
      if (filt_i.code == NO_KEY) begin
        if (committed_q == NO_KEY) begin
          last_d = NO_KEY;
          hold_d = '0;
        end else if (last_q != NO_KEY) begin
          last_d = NO_KEY;
        end else begin
          kind        = EV_RELEASE;
          key         = committed_q;
          committed_d = NO_KEY;
          hold_d      = '0;
        end
      end else if (committed_q == NO_KEY) begin
        if (filt_i.code == last_q) begin
          committed_d = filt_i.code;
          hold_d      = 16'd1;
          kind        = EV_PRESS;
          key         = filt_i.code;
        end else begin
          last_d = filt_i.code;
        end
      end else if (filt_i.code == last_q) begin
        if (committed_q == filt_i.code) begin
          hold_d = hold_inc;
          if (hold_inc == long_hold_ticks_i) begin
            kind = EV_LONG;
            key  = filt_i.code;
          end
        end else begin
          // A different key forces the release of the held one first.
          kind        = EV_RELEASE;
          key         = committed_q;
          hold_d      = '0;
          last_d      = NO_KEY;
          committed_d = NO_KEY;
        end
      end else begin
        last_d = filt_i.code;
      end
    end
  end

  // A release that follows a long hold carries no action.
  always_comb begin
    long_seen_d = long_seen_q;
    action      = ACT_NONE;
    case (kind)
      EV_RELEASE: begin
        if (!long_seen_q) begin
          action = {1'b0, key} + 3'd1;
        end else begin
          long_seen_d = 1'b0;
        end
      end
      EV_LONG: begin
        long_seen_d = 1'b1;
        action      = ACT_RESET;
      end
      default: begin
        action = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= NO_KEY;
      committed_q <= NO_KEY;
      hold_q      <= '0;
      long_seen_q <= 1'b0;
    end else if (step_i) begin
      last_q      <= last_d;
      committed_q <= committed_d;
      hold_q      <= hold_d;
      long_seen_q <= long_seen_d;
    end
  end

  assign result_o.kind     = kind;
  assign result_o.key_id   = key;
  assign result_o.action   = action;
  assign result_o.held_key = committed_d;

endmodule

@@ design/key_debounce_press_release_longhold.sv @@
// Key debounce with press, release and long-hold events.
// Channels: pin_levels_i comes in on in_valid_i/in_ready_o, one scan tick per
// transfer; one result per tick leaves on out_valid_o/out_ready_i with
// event_kind_o, key_id_o, action_o and held_key_o.
// Configuration: cfg_valid_i/cfg_ready_o writes cfg_data_i into the long-hold
// count; cfg_ready_o is always high. Write it only while the block is idle.
// Latency: the result of a tick is presented in the cycle after its transfer.
// Throughput: one tick per clock unless stalled; the encoder, filter compare,
// the 16-bit hold increment and compare sit between state and result register.
// Stall: while a result waits, in_ready_o follows out_ready_i, so a new tick is
// taken in the same cycle the waiting result is taken; the result register
// holds its value until then.
// Reset: the sample history reads no key, no key is held, the hold count is
// zero and the long-hold count returns to 50 ticks.
// FILTER_DEPTH sets how many agreeing samples make a code stable (2 to 8).
module key_debounce_press_release_longhold #(
  parameter int unsigned FILTER_DEPTH = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_kind_o,
  output logic [1:0]  key_id_o,
  output logic [2:0]  action_o,
  output logic [1:0]  held_key_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import kdb_pkg::*;

  logic        step;
  logic        out_valid_q;
  logic [15:0] long_hold_q;
  filt_t       filt;
  result_t     result;
  result_t     result_q;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold_q <= LONG_HOLD_RESET;
    end else if (cfg_valid_i) begin
      long_hold_q <= cfg_data_i;
    end
  end

  kdb_filter #(
    .FILTER_DEPTH(FILTER_DEPTH)
  ) u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pin_levels_i(pin_levels_i),
    .filt_o      (filt)
  );

  kdb_tracker u_tracker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .filt_i           (filt),
    .long_hold_ticks_i(long_hold_q),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = result_q.kind;
  assign key_id_o     = result_q.key_id;
  assign action_o     = result_q.action;
  assign held_key_o   = result_q.held_key;

endmodule

@@ design/kdb_checker.sv @@
// Port-level checker for the key debounce block, bound to the top level.
// Depends on kdb_pkg and key_debounce_press_release_longhold_assert.svh.
`include "key_debounce_press_release_longhold_assert.svh"

module kdb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  event_kind_o,
  input logic [1:0]  key_id_o,
  input logic [2:0]  action_o,
  input logic [1:0]  held_key_o
);
  import kdb_pkg::*;

  // A result that is not taken stays on the port unchanged.
  `KDB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(event_kind_o) && $stable(key_id_o) && $stable(action_o) && $stable(held_key_o), "result changed while stalled")

  // A tick without an event reports key_id KEY_UP and no action.
  `KDB_ASSERT_NOW(a_none_quiet, out_valid_o && event_kind_o == EV_NONE, key_id_o == KEY_UP && action_o == ACT_NONE, "empty event carries key or action")

  // After a press the pressed key is the held key.
  `KDB_ASSERT_NOW(a_press_held, out_valid_o && event_kind_o == EV_PRESS, held_key_o == key_id_o && action_o == ACT_NONE, "press does not hold its key")

  // A release leaves no key held and acts on the released key or not at all.
  `KDB_ASSERT_NOW(a_release_free, out_valid_o && event_kind_o == EV_RELEASE, held_key_o == NO_KEY && (action_o == ACT_NONE || action_o == {1'b0, key_id_o} + 3'd1), "bad release result")

  // A long hold requests a reset while the key is still held.
  `KDB_ASSERT_NOW(a_long_reset, out_valid_o && event_kind_o == EV_LONG, action_o == ACT_RESET && held_key_o == key_id_o, "bad long-hold result")

endmodule

bind key_debounce_press_release_longhold kdb_checker u_kdb_checker (.*);

@@ test/key_debounce_press_release_longhold_tb.sv @@
// Testbench for the key debounce block with press, release and long-hold events.
// Depends on kdb_pkg and key_debounce_press_release_longhold from the design folder.
// Predicts every result from its own copy of the filter and hold state.
module key_debounce_press_release_longhold_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kdb_pkg::*;

  localparam int FLT_DEPTH = 3;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  pin_levels = 3'b111;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  event_kind;
  logic [1:0]  key_id;
  logic [2:0]  action;
  logic [1:0]  held_key;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // Pin samples still to be sent, and the results they must produce.
  logic [2:0] pin_q[$];
  result_t    result_q[$];
  result_t    want;

  int ticks_issued = 0;
  int results_checked = 0;
  int err_cnt = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 55;
  int stall_cycles = 0;

  // Predicted block state.
  logic [1:0]  scan_hist [FLT_DEPTH];
  logic [1:0]  last_code;
  logic [1:0]  held;
  logic [15:0] hold_cnt;
  logic        long_seen;
  logic [15:0] hold_limit;

  always #5 clk = ~clk;

  key_debounce_press_release_longhold #(
    .FILTER_DEPTH(FLT_DEPTH)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .pin_levels_i(pin_levels),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .event_kind_o(event_kind),
    .key_id_o    (key_id),
    .action_o    (action),
    .held_key_o  (held_key),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  function automatic void predict_tick(input logic [2:0] pins);
    logic [1:0] code;
    logic       agree;
    ev_kind_e   kind;
    logic [1:0] key;
    logic [2:0] act;
    result_t    r;
    int         i;
    // The lowest-numbered low pin wins.
    if (!pins[0]) code = KEY_UP;
    else if (!pins[1]) code = KEY_DOWN;
    else if (!pins[2]) code = KEY_CONFIRM;
    else code = NO_KEY;
    for (i = FLT_DEPTH - 1; i > 0; i--) scan_hist[i] = scan_hist[i - 1];
    scan_hist[0] = code;
    agree = 1'b1;
    for (i = 1; i < FLT_DEPTH; i++) if (scan_hist[i] != code) agree = 1'b0;
    kind = EV_NONE;
    key = '0;
    act = ACT_NONE;
    if (agree) begin
      if (code == NO_KEY) begin
        if (held == NO_KEY) begin
          last_code = NO_KEY;
          hold_cnt = '0;
        end else if (last_code != NO_KEY) begin
          last_code = NO_KEY;
        end else begin
          kind = EV_RELEASE;
          key = held;
          held = NO_KEY;
          hold_cnt = '0;
        end
      end else if (held == NO_KEY) begin
        if (code == last_code) begin
          held = code;
          hold_cnt = 16'd1;
          kind = EV_PRESS;
          key = code;
        end else begin
          last_code = code;
        end
      end else if (code == last_code) begin
        if (held == code) begin
          hold_cnt = hold_cnt + 16'd1;
          if (hold_cnt == hold_limit) begin
            kind = EV_LONG;
            key = code;
          end
        end else begin
          // A different key forces the release of the held one.
          kind = EV_RELEASE;
          key = held;
          hold_cnt = '0;
          last_code = NO_KEY;
          held = NO_KEY;
        end
      end else begin
        last_code = code;
      end
    end
    if (kind == EV_RELEASE) begin
      if (!long_seen) act = {1'b0, key} + 3'd1;
      else long_seen = 1'b0;
    end else if (kind == EV_LONG) begin
      long_seen = 1'b1;
      act = ACT_RESET;
    end
    r.kind = kind;
    r.key_id = key;
    r.action = act;
    r.held_key = held;
    result_q.push_back(r);
  endfunction

  // Driver: a tick is predicted when its transfer happens.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      pin_levels <= 3'b111;
      for (int i = 0; i < FLT_DEPTH; i++) scan_hist[i] = NO_KEY;
      last_code = NO_KEY;
      held = NO_KEY;
      hold_cnt = '0;
      long_seen = 1'b0;
      hold_limit = LONG_HOLD_RESET;
    end else begin
      if (in_valid && in_ready) predict_tick(pin_levels);
      if (!in_valid || in_ready) begin
        if (pin_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          pin_levels <= pin_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string field, input int exp_val, input int got_val);
    $error("%s: expected %0d, got %0d", field, exp_val, got_val);
    err_cnt++;
  endtask

  // Monitor: each result transfer is checked against the oldest prediction.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result transfer with no prediction pending");
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          if (event_kind != want.kind) report("event_kind", want.kind, event_kind);
          if (key_id != want.key_id) report("key_id", want.key_id, key_id);
          if (action != want.action) report("action", want.action, action);
          if (held_key != want.held_key) report("held_key", want.held_key, held_key);
        end
        results_checked++;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("key_debounce_press_release_longhold_tb: errors");
        $finish;
      end
    end
  end

  task automatic push_tick(input logic [2:0] lvl);
    pin_q.push_back(lvl);
    ticks_issued++;
  endtask

  task automatic push_run(input logic [2:0] lvl, input int len);
    repeat (len) push_tick(lvl);
  endtask

  // Random pin level that still encodes to the given key.
  function automatic logic [2:0] key_level(input logic [1:0] k);
    logic [2:0] lvl;
    lvl = 3'($urandom_range(0, 7));
    case (k)
      KEY_UP: lvl[0] = 1'b0;
      KEY_DOWN: lvl[1:0] = 2'b01;
      KEY_CONFIRM: lvl = 3'b011;
      default: lvl = 3'b111;
    endcase
    return lvl;
  endfunction

  task automatic push_key_run(input logic [1:0] k, input int len);
    repeat (len) push_tick(key_level(k));
  endtask

  // Mostly held keys long enough to commit and often to reach the long hold,
  // with idle stretches between them and some single-tick glitches.
  task automatic add_random_ticks(input int n);
    int made;
    int pick;
    int len;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        len = $urandom_range(1, hold_limit + 6);
        push_key_run(2'($urandom_range(0, 2)), len);
      end else if (pick < 8) begin
        len = $urandom_range(1, 8);
        push_run(3'b111, len);
      end else begin
        len = 1;
        push_tick(3'($urandom_range(0, 7)));
      end
      made += len;
    end
  endtask

  task automatic settle();
    while (ticks_issued != results_checked) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_hold_limit(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    hold_limit = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    write_hold_limit(16'd2);
    // Up held into a long hold, then down forces a release with no action.
    push_run(3'b000, 5);
    push_run(3'b001, 6);
    push_run(3'b111, 4);
    // Confirm press, a glitch that never settles, then a normal release.
    push_run(3'b011, 4);
    push_tick(3'b101);
    push_tick(3'b010);
    push_tick(3'b100);
    push_run(3'b111, 4);
    add_random_ticks(480);
    settle();

    send_idle_pct = 55;
    recv_idle_pct = 19;
    write_hold_limit(16'($urandom_range(3, 30)));
    add_random_ticks(500);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_hold_limit(LONG_HOLD_RESET);
    add_random_ticks(500);
    settle();

    if (err_cnt == 0) begin
      $display("key_debounce_press_release_longhold_tb: clean");
    end else begin
      $display("key_debounce_press_release_longhold_tb: errors");
    end
    $finish;
  end

endmodule

@@ key_debounce_press_release_longhold.f @@
+incdir+design
design/kdb_pkg.sv
design/kdb_filter.sv
design/kdb_tracker.sv
design/key_debounce_press_release_longhold.sv
design/kdb_checker.sv
test/key_debounce_press_release_longhold_tb.sv
